### hw/rtl/lmrs_pkg.sv
package lmrs_pkg;

  localparam int STORE_AW    = 12;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int PIX_W       = 3;
  localparam int ROW_W       = 5;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAME_W     = 32;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam logic [CFG_W-1:0] RST_PANEL_COLUMNS = 7'd64;
  localparam logic [CFG_W-1:0] RST_PANEL_ROWS    = 7'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_ROWS    = 2'd1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [STORE_AW-1:0] pixel_index;
    logic                red;
    logic                green;
    logic                blue;
  } in_t;

  typedef struct packed {
    logic               output_enable;
    logic [ROW_W-1:0]   row_address;
    logic               upper_red;
    logic               upper_green;
    logic               upper_blue;
    logic               lower_red;
    logic               lower_green;
    logic               lower_blue;
    logic               shift_clock;
    logic               latch_strobe;
    logic               busy_res;
    logic [FRAME_W-1:0] frames_done;
  } out_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [PIX_W-1:0]    data;
  } store_wr_t;

endpackage

### hw/rtl/lmrs_store.sv
module lmrs_store
  import lmrs_pkg::*;
(
  input  logic                clk,
  input  store_wr_t           wr,
  input  logic [STORE_AW-1:0] rd_addr_up,
  input  logic [STORE_AW-1:0] rd_addr_lo,
  output logic [PIX_W-1:0]    rd_data_up,
  output logic [PIX_W-1:0]    rd_data_lo
);

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rd_up_r;
  logic [PIX_W-1:0] rd_lo_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_up_r <= mem[rd_addr_up];
    rd_lo_r <= mem[rd_addr_lo];
  end

  assign rd_data_up = rd_up_r;
  assign rd_data_lo = rd_lo_r;

endmodule

### hw/rtl/lmrs_seq.sv
module lmrs_seq
  import lmrs_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  in_t                 cmd,
  input  logic [CFG_W-1:0]    panel_columns,
  input  logic [CFG_W-1:0]    panel_rows,
  input  logic [PIX_W-1:0]    rd_data_up,
  input  logic [PIX_W-1:0]    rd_data_lo,
  output store_wr_t           wr,
  output logic [STORE_AW-1:0] rd_addr_up,
  output logic [STORE_AW-1:0] rd_addr_lo,
  output logic                busy,
  output out_t                view
);

  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int CCMP_W  = (COL_W > CFG_W) ? COL_W : CFG_W;
  localparam int RSAT_W  = $clog2(MAX_ROWS + 1);
  localparam int RCMP_W  = (RSAT_W > CFG_W) ? RSAT_W : CFG_W;
  localparam int PAIR_W  = $clog2(MAX_ROWS / 2 + 1);
  localparam int RINC_W  = (ROW_W + 1 > PAIR_W) ? ROW_W + 1 : PAIR_W;
  localparam int PROD_W  = PAIR_W + COL_W;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_ADDR    = 7'b0000010,
    PH_DATA    = 7'b0000100,
    PH_CLKHI   = 7'b0001000,
    PH_STBHI   = 7'b0010000,
    PH_STBLO   = 7'b0100000,
    PH_UNBLANK = 7'b1000000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [STORE_AW-1:0] base_r, base_nxt;
  logic [FRAME_W-1:0]  frames_r, frames_nxt;
  logic                oe_r, oe_nxt;
  logic [ROW_W-1:0]    addr_pin_r, addr_pin_nxt;
  logic [PIX_W-1:0]    upper_r, upper_nxt;
  logic [PIX_W-1:0]    lower_r, lower_nxt;
  logic                sclk_r, sclk_nxt;
  logic                stb_r, stb_nxt;
  logic [STORE_AW-1:0] half_r;

  logic [CCMP_W-1:0]   cols_ext;
  logic [COL_W-1:0]    cols;
  logic [RCMP_W-1:0]   rows_ext;
  logic [RCMP_W-1:0]   rows_sat;
  logic [PAIR_W-1:0]   pairs;
  logic [PROD_W-1:0]   prod;
  logic [COL_W-1:0]    col_inc;
  logic [RINC_W-1:0]   row_inc;

  assign cols_ext = CCMP_W'(panel_columns);
  assign cols     = (cols_ext > CCMP_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : COL_W'(cols_ext);
  assign rows_ext = RCMP_W'(panel_rows);
  assign rows_sat = (rows_ext > RCMP_W'(MAX_ROWS)) ? RCMP_W'(MAX_ROWS) : rows_ext;
  assign pairs    = PAIR_W'(rows_sat >> 1);
  assign prod     = PROD_W'(pairs) * PROD_W'(cols);
  assign col_inc  = col_r + COL_W'(1);
  assign row_inc  = RINC_W'(row_r) + RINC_W'(1);
  assign busy     = (phase_r != PH_IDLE);

  always_comb begin
    phase_nxt    = phase_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    base_nxt     = base_r;
    frames_nxt   = frames_r;
    oe_nxt       = oe_r;
    addr_pin_nxt = addr_pin_r;
    upper_nxt    = upper_r;
    lower_nxt    = lower_r;
    sclk_nxt     = sclk_r;
    stb_nxt      = stb_r;
    wr           = '0;
    if (step) begin
      case (cmd.opcode)
        OP_WRITE: begin
          if (!busy) begin
            wr.en   = 1'b1;
            wr.addr = cmd.pixel_index;
            wr.data = {cmd.blue, cmd.green, cmd.red};
          end
        end
        OP_FLUSH: begin
          if (!busy) begin
            oe_nxt    = 1'b1;
            row_nxt   = '0;
            col_nxt   = '0;
            base_nxt  = '0;
            phase_nxt = (pairs != '0) ? PH_ADDR : PH_UNBLANK;
          end
        end
        OP_TICK: begin
          unique case (phase_r)
            PH_IDLE: begin
            end
            PH_ADDR: begin
              addr_pin_nxt = row_r;
              sclk_nxt     = 1'b0;
              col_nxt      = '0;
              phase_nxt    = (cols != '0) ? PH_DATA : PH_STBHI;
            end
            PH_DATA: begin
              upper_nxt = rd_data_up;
              lower_nxt = rd_data_lo;
              sclk_nxt  = 1'b0;
              phase_nxt = PH_CLKHI;
            end
            PH_CLKHI: begin
              sclk_nxt  = 1'b1;
              col_nxt   = col_inc;
              phase_nxt = (col_inc < cols) ? PH_DATA : PH_STBHI;
            end
            PH_STBHI: begin
              sclk_nxt  = 1'b0;
              stb_nxt   = 1'b1;
              phase_nxt = PH_STBLO;
            end
            PH_STBLO: begin
              stb_nxt = 1'b0;
              if (row_inc < RINC_W'(pairs)) begin
                row_nxt   = ROW_W'(row_inc);
                base_nxt  = base_r + STORE_AW'(cols);
                phase_nxt = PH_ADDR;
              end else begin
                phase_nxt = PH_UNBLANK;
              end
            end
            PH_UNBLANK: begin
              oe_nxt     = 1'b0;
              frames_nxt = frames_r + FRAME_W'(1);
              phase_nxt  = PH_IDLE;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // The store is read every cycle at the address of the coming scan state, so the
  // pixel pair is already registered when a data tick arrives.
  assign rd_addr_up = base_nxt + STORE_AW'(col_nxt);
  assign rd_addr_lo = rd_addr_up + half_r;

  always_ff @(posedge clk) begin
    half_r <= STORE_AW'(prod);
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      row_r      <= '0;
      col_r      <= '0;
      base_r     <= '0;
      frames_r   <= '0;
      oe_r       <= 1'b0;
      addr_pin_r <= '0;
      upper_r    <= '0;
      lower_r    <= '0;
      sclk_r     <= 1'b0;
      stb_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      base_r     <= base_nxt;
      frames_r   <= frames_nxt;
      oe_r       <= oe_nxt;
      addr_pin_r <= addr_pin_nxt;
      upper_r    <= upper_nxt;
      lower_r    <= lower_nxt;
      sclk_r     <= sclk_nxt;
      stb_r      <= stb_nxt;
    end
  end

  assign view.output_enable = oe_r;
  assign view.row_address   = addr_pin_r;
  assign view.upper_red     = upper_r[0];
  assign view.upper_green   = upper_r[1];
  assign view.upper_blue    = upper_r[2];
  assign view.lower_red     = lower_r[0];
  assign view.lower_green   = lower_r[1];
  assign view.lower_blue    = lower_r[2];
  assign view.shift_clock   = sclk_r;
  assign view.latch_strobe  = stb_r;
  assign view.busy_res      = busy;
  assign view.frames_done   = frames_r;

endmodule

### hw/rtl/led_matrix_row_scan.sv
// Scan driver for a dual-channel RGB LED panel with one bit per color. Every accepted
// item yields exactly one result carrying the pin levels after that item: pixel writes
// fill a 4096-entry frame store, a flush blanks the display and arms a scan, and each
// tick advances the panel sequence by one pin step. An item is taken every clock cycle
// as long as the result side keeps up; the scan state registers themselves hold the
// result, and the frame store is read ahead at the address of the next scan state
// through its two registered read ports, so a data tick never waits on memory.
// Pixel writes, flushes and register writes that arrive during a scan are dropped.
// The frame store has no reset; a scan must only touch pixels that were written.
module led_matrix_row_scan
  import lmrs_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic                out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]    cols_cfg_r;
  logic [CFG_W-1:0]    rows_cfg_r;
  logic                in_fire;
  logic                busy;
  store_wr_t           st_wr;
  logic [STORE_AW-1:0] rd_addr_up;
  logic [STORE_AW-1:0] rd_addr_lo;
  logic [PIX_W-1:0]    rd_data_up;
  logic [PIX_W-1:0]    rd_data_lo;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cols_cfg_r  <= RST_PANEL_COLUMNS;
      rows_cfg_r  <= RST_PANEL_ROWS;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && !busy) begin
        unique case (cfg_index)
          CFG_PANEL_COLUMNS: cols_cfg_r <= cfg_data;
          CFG_PANEL_ROWS:    rows_cfg_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  lmrs_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_fire),
    .cmd           (in_data),
    .panel_columns (cols_cfg_r),
    .panel_rows    (rows_cfg_r),
    .rd_data_up    (rd_data_up),
    .rd_data_lo    (rd_data_lo),
    .wr            (st_wr),
    .rd_addr_up    (rd_addr_up),
    .rd_addr_lo    (rd_addr_lo),
    .busy          (busy),
    .view          (out_data)
  );

  lmrs_store u_store (
    .clk        (clk),
    .wr         (st_wr),
    .rd_addr_up (rd_addr_up),
    .rd_addr_lo (rd_addr_lo),
    .rd_data_up (rd_data_up),
    .rd_data_lo (rd_data_lo)
  );

  a_busy_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_data.busy_res) |-> $past(in_fire && in_data.opcode == OP_FLUSH))
    else $error("scan started without a flush transfer");

  a_frames_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(out_data.frames_done))
    else $error("frame count changed without an input transfer");

  a_clk_stb_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_data.shift_clock && out_data.latch_strobe))
    else $error("shift clock and latch strobe high together");

endmodule

### dv/led_matrix_row_scan_test.sv
`timescale 1ns / 1ps

module led_matrix_row_scan_test;
  import lmrs_pkg::*;

  localparam logic [1:0]           OP_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_ADDR,
    SCAN_DATA,
    SCAN_CLK_HIGH,
    SCAN_LATCH_HIGH,
    SCAN_LATCH_LOW,
    SCAN_UNBLANK
  } scan_phase_e;

  typedef enum logic {ROW_ITEM, ROW_REG} plan_kind_e;

  typedef struct {
    plan_kind_e           kind;
    in_t                  item;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     reg_value;
    bit                   typed;
    out_t                 levels;
  } plan_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic [PIX_W-1:0]   pixels [STORE_DEPTH];
  bit                 pixel_written [STORE_DEPTH];
  scan_phase_e        phase        = SCAN_IDLE;
  int unsigned        row_ptr      = 0;
  int unsigned        col_ptr      = 0;
  logic [CFG_W-1:0]   columns_reg  = RST_PANEL_COLUMNS;
  logic [CFG_W-1:0]   rows_reg     = RST_PANEL_ROWS;
  logic [FRAME_W-1:0] frames_total = '0;
  out_t               pins         = '0;

  out_t        expected_pins [$];
  plan_row_t   plan [$];
  int          failures      = 0;
  int          stall_cycles  = 0;
  int unsigned applied_items = 0;
  bit          calm          = 1'b0;

  led_matrix_row_scan uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned active_columns();
    return (columns_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : columns_reg;
  endfunction

  function automatic int unsigned row_pairs();
    int unsigned rows;
    rows = (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_reg;
    return rows / 2;
  endfunction

  function automatic void advance_scan();
    int unsigned cols;
    int unsigned pairs;
    int unsigned upper_idx;
    int unsigned lower_idx;
    cols  = active_columns();
    pairs = row_pairs();
    case (phase)
      SCAN_ADDR: begin
        pins.row_address = ROW_W'(row_ptr);
        pins.shift_clock = 1'b0;
        col_ptr = 0;
        phase = (cols > 0) ? SCAN_DATA : SCAN_LATCH_HIGH;
      end
      SCAN_DATA: begin
        upper_idx = (row_ptr * cols + col_ptr) % STORE_DEPTH;
        lower_idx = (upper_idx + pairs * cols) % STORE_DEPTH;
        {pins.upper_blue, pins.upper_green, pins.upper_red} = pixels[upper_idx];
        {pins.lower_blue, pins.lower_green, pins.lower_red} = pixels[lower_idx];
        pins.shift_clock = 1'b0;
        phase = SCAN_CLK_HIGH;
      end
      SCAN_CLK_HIGH: begin
        pins.shift_clock = 1'b1;
        col_ptr++;
        phase = (col_ptr < cols) ? SCAN_DATA : SCAN_LATCH_HIGH;
      end
      SCAN_LATCH_HIGH: begin
        pins.shift_clock  = 1'b0;
        pins.latch_strobe = 1'b1;
        phase = SCAN_LATCH_LOW;
      end
      SCAN_LATCH_LOW: begin
        pins.latch_strobe = 1'b0;
        if (row_ptr + 1 < pairs) begin
          row_ptr++;
          phase = SCAN_ADDR;
        end else begin
          phase = SCAN_UNBLANK;
        end
      end
      SCAN_UNBLANK: begin
        pins.output_enable = 1'b0;
        frames_total++;
        phase = SCAN_IDLE;
      end
      default: ;
    endcase
  endfunction

  function automatic out_t next_pins(in_t item);
    bit   idle;
    out_t levels;
    idle = (phase == SCAN_IDLE);
    case (item.opcode)
      OP_WRITE: begin
        if (idle) begin
          pixels[item.pixel_index] = {item.blue, item.green, item.red};
          pixel_written[item.pixel_index] = 1'b1;
        end
      end
      OP_FLUSH: begin
        if (idle) begin
          pins.output_enable = 1'b1;
          row_ptr = 0;
          col_ptr = 0;
          phase = (row_pairs() > 0) ? SCAN_ADDR : SCAN_UNBLANK;
        end
      end
      OP_TICK: advance_scan();
      default: ;
    endcase
    levels = pins;
    levels.busy_res    = (phase != SCAN_IDLE);
    levels.frames_done = frames_total;
    return levels;
  endfunction

  function automatic in_t make_item(logic [1:0] op, logic [STORE_AW-1:0] idx,
                                    logic [2:0] rgb);
    in_t item;
    item.opcode      = op;
    item.pixel_index = idx;
    item.red         = rgb[2];
    item.green       = rgb[1];
    item.blue        = rgb[0];
    return item;
  endfunction

  function automatic in_t random_item();
    return make_item(2'($urandom_range(0, 3)), STORE_AW'($urandom_range(0, 4095)),
                     3'($urandom_range(0, 7)));
  endfunction

  function automatic plan_row_t item_row(logic [1:0] op, logic [STORE_AW-1:0] idx,
                                         logic [2:0] rgb);
    plan_row_t row;
    row.kind      = ROW_ITEM;
    row.item      = make_item(op, idx, rgb);
    row.reg_index = '0;
    row.reg_value = '0;
    row.typed     = 1'b0;
    row.levels    = '0;
    return row;
  endfunction

  function automatic plan_row_t pin_row(logic [1:0] op, logic [STORE_AW-1:0] idx,
                                        logic [2:0] rgb, logic oe, logic busy,
                                        logic [FRAME_W-1:0] frames);
    plan_row_t row;
    row = item_row(op, idx, rgb);
    row.typed                = 1'b1;
    row.levels.output_enable = oe;
    row.levels.busy_res      = busy;
    row.levels.frames_done   = frames;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] reg_index,
                                        logic [CFG_W-1:0] value);
    plan_row_t row;
    row = item_row(OP_SPARE, '0, '0);
    row.kind      = ROW_REG;
    row.reg_index = reg_index;
    row.reg_value = value;
    return row;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input in_t item, input bit typed, input out_t typed_levels);
    int unsigned gap;
    bit          was_busy;
    out_t        predicted;
    gap = idle_len();
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    was_busy  = (phase != SCAN_IDLE);
    predicted = next_pins(item);
    expected_pins.push_back(typed ? typed_levels : predicted);
    if ((item.opcode == OP_TICK && was_busy) ||
        ((item.opcode == OP_WRITE || item.opcode == OP_FLUSH) && !was_busy)) begin
      applied_items++;
    end
  endtask

  task automatic drain();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (expected_pins.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                           input logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (phase == SCAN_IDLE) begin
      case (reg_index)
        CFG_PANEL_COLUMNS: columns_reg = value;
        CFG_PANEL_ROWS:    rows_reg    = value;
        default: ;
      endcase
    end
  endtask

  task automatic send_write(input int unsigned idx);
    send_item(make_item(OP_WRITE, STORE_AW'(idx), 3'($urandom_range(0, 7))), 1'b0, '0);
  endtask

  task automatic run_scan_phase(input bit full_size);
    int unsigned cols;
    int unsigned rows;
    int unsigned span;
    int unsigned i;
    in_t         item;
    calm = ($urandom_range(0, 3) == 0);
    if (full_size) begin
      cols = ($urandom_range(0, 1) != 0) ? DEF_MAX_COLUMNS : $urandom_range(65, 127);
      rows = ($urandom_range(0, 1) != 0) ? DEF_MAX_ROWS : $urandom_range(65, 127);
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          cols = $urandom_range(0, 127);
          rows = $urandom_range(0, 3);
        end
        1: begin
          cols = $urandom_range(0, 2);
          rows = $urandom_range(0, 127);
        end
        default: begin
          cols = $urandom_range(1, 6);
          rows = $urandom_range(2, 8);
        end
      endcase
    end
    write_reg(CFG_PANEL_COLUMNS, CFG_W'(cols));
    write_reg(CFG_PANEL_ROWS, CFG_W'(rows));
    if ($urandom_range(0, 7) == 0) begin
      write_reg(($urandom_range(0, 1) != 0) ? CFG_UNUSED_A : CFG_UNUSED_B,
                CFG_W'($urandom_range(0, 127)));
    end
    span = 2 * row_pairs() * active_columns();

    if (!full_size && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) begin
        item = random_item();
        if (item.opcode == OP_FLUSH) item.opcode = OP_SPARE;
        send_item(item, 1'b0, '0);
      end
      return;
    end

    // Every pixel the scan will read must hold a written value first.
    for (i = 0; i < span; i++) begin
      if (!pixel_written[i]) send_write(i);
    end
    repeat ($urandom_range(0, 6)) send_write($urandom_range(0, 4095));
    if (span > 0) begin
      repeat ($urandom_range(0, 4)) send_write($urandom_range(0, span - 1));
    end

    send_item(make_item(OP_FLUSH, STORE_AW'($urandom_range(0, 4095)),
                        3'($urandom_range(0, 7))), 1'b0, '0);
    while (phase != SCAN_IDLE) begin
      if (full_size || $urandom_range(0, 19) > 2) begin
        item = make_item(OP_TICK, STORE_AW'($urandom_range(0, 4095)),
                         3'($urandom_range(0, 7)));
      end else begin
        item = random_item();
      end
      send_item(item, 1'b0, '0);
    end
    repeat ($urandom_range(0, 2)) begin
      send_item(make_item(OP_TICK, STORE_AW'($urandom_range(0, 4095)), 3'b000), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [FRAME_W-1:0] want,
                             input logic [FRAME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = idle_len();
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pins.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %h", $time, out_data);
        failures++;
      end else begin
        want = expected_pins.pop_front();
        check_field("output_enable", FRAME_W'(want.output_enable),
                    FRAME_W'(out_data.output_enable));
        check_field("row_address", FRAME_W'(want.row_address),
                    FRAME_W'(out_data.row_address));
        check_field("upper_red", FRAME_W'(want.upper_red), FRAME_W'(out_data.upper_red));
        check_field("upper_green", FRAME_W'(want.upper_green),
                    FRAME_W'(out_data.upper_green));
        check_field("upper_blue", FRAME_W'(want.upper_blue), FRAME_W'(out_data.upper_blue));
        check_field("lower_red", FRAME_W'(want.lower_red), FRAME_W'(out_data.lower_red));
        check_field("lower_green", FRAME_W'(want.lower_green),
                    FRAME_W'(out_data.lower_green));
        check_field("lower_blue", FRAME_W'(want.lower_blue), FRAME_W'(out_data.lower_blue));
        check_field("shift_clock", FRAME_W'(want.shift_clock),
                    FRAME_W'(out_data.shift_clock));
        check_field("latch_strobe", FRAME_W'(want.latch_strobe),
                    FRAME_W'(out_data.latch_strobe));
        check_field("busy_res", FRAME_W'(want.busy_res), FRAME_W'(out_data.busy_res));
        check_field("frames_done", want.frames_done, out_data.frames_done);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    // Idle ticks, pixel writes and busy-time commands leave the pins as they are.
    plan.push_back(pin_row(OP_TICK, 12'd0, 3'b000, 1'b0, 1'b0, 32'd0));
    plan.push_back(pin_row(OP_SPARE, 12'hFFF, 3'b111, 1'b0, 1'b0, 32'd0));
    plan.push_back(reg_row(CFG_PANEL_COLUMNS, 7'd1));
    plan.push_back(reg_row(CFG_PANEL_ROWS, 7'd2));
    plan.push_back(pin_row(OP_WRITE, 12'd0, 3'b101, 1'b0, 1'b0, 32'd0));
    plan.push_back(pin_row(OP_WRITE, 12'd1, 3'b010, 1'b0, 1'b0, 32'd0));
    plan.push_back(pin_row(OP_WRITE, 12'hFFF, 3'b111, 1'b0, 1'b0, 32'd0));
    plan.push_back(pin_row(OP_FLUSH, 12'd0, 3'b000, 1'b1, 1'b1, 32'd0));
    plan.push_back(pin_row(OP_WRITE, 12'd0, 3'b000, 1'b1, 1'b1, 32'd0));
    plan.push_back(pin_row(OP_FLUSH, 12'd0, 3'b000, 1'b1, 1'b1, 32'd0));
    repeat (7) plan.push_back(item_row(OP_TICK, 12'd0, 3'b000));
    plan.push_back(reg_row(CFG_PANEL_ROWS, 7'd0));
    plan.push_back(item_row(OP_FLUSH, 12'd0, 3'b000));
    plan.push_back(item_row(OP_TICK, 12'd0, 3'b000));
    plan.push_back(reg_row(CFG_PANEL_COLUMNS, 7'd0));
    plan.push_back(reg_row(CFG_PANEL_ROWS, 7'd4));
    plan.push_back(reg_row(CFG_UNUSED_A, 7'h7F));
    plan.push_back(reg_row(CFG_UNUSED_B, 7'h55));
    plan.push_back(item_row(OP_FLUSH, 12'hFFF, 3'b111));
    plan.push_back(reg_row(CFG_PANEL_COLUMNS, 7'd3));
    repeat (7) plan.push_back(item_row(OP_TICK, 12'd0, 3'b000));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].levels);
      end
    end

    applied_items = 0;
    while (applied_items < RANDOM_ITEMS) run_scan_phase(1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lmrs_pkg.sv
hw/rtl/lmrs_store.sv
hw/rtl/lmrs_seq.sv
hw/rtl/led_matrix_row_scan.sv
dv/led_matrix_row_scan_test.sv
